@@ hdl/dmc_pkg.sv @@
// Shared types, widths and defaults for the direct-mapped write-through cache.
package dmc_pkg;

	localparam int ADDR_W    = 16;
	localparam int DATA_W    = 64;
	localparam int CNT_W     = 4;
	localparam int CMD_W     = 2;
	localparam int MAX_COUNT = 8;
	localparam int LANE_W    = 3;

	localparam int NUM_LINES_DEF  = 1024;
	localparam int LINE_BYTES_DEF = 16;
	localparam int MEM_BYTES_DEF  = 65536;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_LOAD  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_COMPARE,
		ST_FILL,
		ST_ACCESS,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic tag_clr;
		logic tag_wr;
		logic eval;
		logic count_hit;
		logic count_miss;
		logic step_clr;
		logic step_inc;
		logic fill;
		logic access;
		logic out_load;
	} dmc_ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic             clr_last;
		logic [CMD_W-1:0] cmd;
		logic             hit;
		logic             fill_done;
		logic             acc_done;
		logic             out_free;
	} dmc_stat_t;

endpackage

@@ hdl/dmc_req_if.sv @@
// Request channel: command, address, write bytes and byte count.
interface dmc_req_if import dmc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] store_data;
	logic [CNT_W-1:0]  byte_count;

	modport source (output valid, command, address, store_data, byte_count, input ready);
	modport sink (input valid, command, address, store_data, byte_count, output ready);
endinterface

@@ hdl/dmc_rsp_if.sv @@
// Response channel: read bytes, hit flag and running counters.
interface dmc_rsp_if import dmc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              was_hit;
	logic [31:0]       hits_total;
	logic [31:0]       misses_total;

	modport source (output valid, read_data, was_hit, hits_total, misses_total, input ready);
	modport sink (input valid, read_data, was_hit, hits_total, misses_total, output ready);
endinterface

@@ hdl/direct_mapped_write_through_cache_top.sv @@
// Top level of the direct-mapped, write-through, write-allocate cache.
//
// Direct-mapped cache of NUM_LINES lines of LINE_BYTES bytes in front of a
// byte-wide backing memory of MEM_BYTES bytes. Each request transfer is a read,
// a write, a load that puts bytes straight into backing memory, or the unused
// fourth code, which does nothing; each gives exactly one response transfer
// with the read bytes, the hit flag and the hit and miss totals after the
// request. After reset the block sweeps all NUM_LINES lines (1024 by default) of
// the tag store, one line per cycle, before it takes the first request.
// One request is worked at a time; its byte count runs from 0 to 8, larger
// counts being taken as 8. A miss fills the line first, streaming one byte per
// cycle through the single read port of the backing memory. The line and
// backing memories are byte-wide, so every byte read, written or filled takes
// its own port access. A finished response sits in an output register so the
// next request can be taken while it waits. For reads and writes, bytes that
// fall past the end of the line read as zero and are not written; loads write
// them to backing memory. Backing memory bytes that were never loaded or
// written hold no defined value.
module direct_mapped_write_through_cache_top import dmc_pkg::*; #(
	parameter int NUM_LINES  = NUM_LINES_DEF,
	parameter int LINE_BYTES = LINE_BYTES_DEF,
	parameter int MEM_BYTES  = MEM_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	dmc_req_if.sink    req,
	dmc_rsp_if.source  rsp
);

	dmc_ctrl_t ctrl;
	dmc_stat_t st;

	// sequencing: clear sweep, lookup, fill, byte steps, response handoff
	dmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.ctrl      (ctrl)
	);

	// storage, address math, counters and the response register
	dmc_datapath #(
		.NUM_LINES  (NUM_LINES),
		.LINE_BYTES (LINE_BYTES),
		.MEM_BYTES  (MEM_BYTES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.st               (st),
		.in_command       (req.command),
		.in_address       (req.address),
		.in_store_data    (req.store_data),
		.in_byte_count    (req.byte_count),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_read_data    (rsp.read_data),
		.out_was_hit      (rsp.was_hit),
		.out_hits_total   (rsp.hits_total),
		.out_misses_total (rsp.misses_total)
	);

endmodule

@@ hdl/dmc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/dmc_ctrl.sv @@
// Controller state machine: clear sweep, lookup, fill, byte access, result handoff.
module dmc_ctrl import dmc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  dmc_stat_t st,
	output dmc_ctrl_t ctrl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctrl.tag_clr = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctrl.accept = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				// tag read goes out here for every command
				ctrl.step_clr = 1'b1;
				case (st.cmd)
					CMD_READ, CMD_WRITE: state_d = ST_COMPARE;
					CMD_LOAD:            state_d = ST_ACCESS;
					default:             state_d = ST_FINISH;
				endcase
			end
			ST_COMPARE: begin
				ctrl.eval     = 1'b1;
				ctrl.step_clr = 1'b1;
				if (st.hit) begin
					ctrl.count_hit = 1'b1;
					state_d        = ST_ACCESS;
				end else begin
					ctrl.count_miss = 1'b1;
					ctrl.tag_wr     = 1'b1;
					state_d         = ST_FILL;
				end
			end
			ST_FILL: begin
				ctrl.fill = 1'b1;
				if (st.fill_done) begin
					ctrl.step_clr = 1'b1;
					state_d       = ST_ACCESS;
				end else begin
					ctrl.step_inc = 1'b1;
				end
			end
			ST_ACCESS: begin
				ctrl.access = 1'b1;
				if (st.acc_done) begin
					state_d = ST_FINISH;
				end else begin
					ctrl.step_inc = 1'b1;
				end
			end
			ST_FINISH: begin
				if (st.out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/dmc_datapath.sv @@
// Datapath: item registers, tag/line/backing RAMs, counters and result register.
module dmc_datapath import dmc_pkg::*; #(
	parameter int NUM_LINES  = NUM_LINES_DEF,
	parameter int LINE_BYTES = LINE_BYTES_DEF,
	parameter int MEM_BYTES  = MEM_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dmc_ctrl_t         ctrl,
	output dmc_stat_t         st,
	input  logic [CMD_W-1:0]  in_command,
	input  logic [ADDR_W-1:0] in_address,
	input  logic [DATA_W-1:0] in_store_data,
	input  logic [CNT_W-1:0]  in_byte_count,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_read_data,
	output logic              out_was_hit,
	output logic [31:0]       out_hits_total,
	output logic [31:0]       out_misses_total
);

	localparam int EXT_W      = 32;
	localparam int OFF_W      = $clog2(LINE_BYTES);
	localparam int IDX_W      = $clog2(NUM_LINES);
	localparam int MEM_AW     = $clog2(MEM_BYTES);
	localparam int TAG_W      = (ADDR_W > OFF_W + IDX_W) ? ADDR_W - OFF_W - IDX_W : 1;
	localparam int STEP_W     = OFF_W + 1;
	localparam int LINE_AW    = IDX_W + OFF_W;
	localparam int LINE_DEPTH = NUM_LINES * LINE_BYTES;

	// item registers
	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] wdata_q;
	logic [CNT_W-1:0]  cnt_q;

	// control state
	logic [IDX_W-1:0]  clr_q;
	logic [STEP_W-1:0] step_q;
	logic              rd_pend_q;
	logic              out_valid_q;
	logic              hit_q;
	logic [31:0]       hits_q;
	logic [31:0]       misses_q;

	logic [LANE_W-1:0] rd_lane_q;
	logic [DATA_W-1:0] rdata_q;

	// address split
	logic [EXT_W-1:0]   addr_ext;
	logic [EXT_W-1:0]   line_sel;
	logic [EXT_W-1:0]   tag_sel;
	logic [EXT_W-1:0]   base_ext;
	logic [IDX_W-1:0]   idx;
	logic [TAG_W-1:0]   tag;
	logic [OFF_W-1:0]   off;
	logic [STEP_W-1:0]  pos;
	logic [STEP_W-1:0]  fill_prev;
	logic [OFF_W-1:0]   fill_off;
	logic [EXT_W-1:0]   fill_sum;
	logic [EXT_W-1:0]   wr_sum;
	logic [STEP_W-1:0]  cnt_ext;

	logic               in_line;
	logic               acc_active;
	logic               rd_issue;
	logic [7:0]         wr_byte;
	logic [CNT_W-1:0]   cnt_sat;

	// RAM ports
	logic               tag_we;
	logic [IDX_W-1:0]   tag_addr;
	logic [TAG_W:0]     tag_wdata;
	logic [TAG_W:0]     tag_rdata;
	logic               line_we;
	logic [LINE_AW-1:0] line_waddr;
	logic [7:0]         line_wdata;
	logic [LINE_AW-1:0] line_raddr;
	logic [7:0]         line_rdata;
	logic               mem_we;
	logic [MEM_AW-1:0]  mem_waddr;
	logic [MEM_AW-1:0]  mem_raddr;
	logic [7:0]         mem_rdata;

	assign addr_ext  = EXT_W'(addr_q);
	assign line_sel  = addr_ext >> OFF_W;
	assign tag_sel   = addr_ext >> (OFF_W + IDX_W);
	assign base_ext  = line_sel << OFF_W;
	assign idx       = line_sel[IDX_W-1:0];
	assign tag       = tag_sel[TAG_W-1:0];
	assign off       = addr_q[OFF_W-1:0];
	assign pos       = {1'b0, off} + step_q;
	assign fill_prev = step_q - 1'b1;
	assign fill_off  = fill_prev[OFF_W-1:0];
	assign fill_sum  = base_ext + EXT_W'(step_q);
	assign wr_sum    = addr_ext + EXT_W'(step_q);
	assign cnt_ext   = STEP_W'(cnt_q);
	assign cnt_sat   = (in_byte_count > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : in_byte_count;

	assign in_line    = pos < STEP_W'(LINE_BYTES);
	assign acc_active = (step_q < cnt_ext) && ((cmd_q == CMD_LOAD) || in_line);
	assign rd_issue   = ctrl.access && acc_active && (cmd_q == CMD_READ);
	assign wr_byte    = wdata_q[{step_q[LANE_W-1:0], 3'b000} +: 8];

	// tag store: {valid, tag}
	assign tag_we    = ctrl.tag_clr || ctrl.tag_wr;
	assign tag_addr  = ctrl.tag_clr ? clr_q : idx;
	assign tag_wdata = ctrl.tag_clr ? '0 : {1'b1, tag};

	// line store: fill writes the byte read one step earlier
	assign line_we    = (ctrl.fill && (step_q != '0))
		|| (ctrl.access && acc_active && (cmd_q == CMD_WRITE));
	assign line_waddr = ctrl.fill ? {idx, fill_off} : {idx, pos[OFF_W-1:0]};
	assign line_wdata = ctrl.fill ? mem_rdata : wr_byte;
	assign line_raddr = {idx, pos[OFF_W-1:0]};

	// backing memory
	assign mem_we    = ctrl.access && acc_active
		&& ((cmd_q == CMD_WRITE) || (cmd_q == CMD_LOAD));
	assign mem_waddr = wr_sum[MEM_AW-1:0];
	assign mem_raddr = fill_sum[MEM_AW-1:0];

	dmc_ram #(.WIDTH(TAG_W + 1), .DEPTH(NUM_LINES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_addr),
		.wdata (tag_wdata),
		.raddr (tag_addr),
		.rdata (tag_rdata)
	);

	dmc_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_waddr),
		.wdata (line_wdata),
		.raddr (line_raddr),
		.rdata (line_rdata)
	);

	dmc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (wr_byte),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign st.clr_last  = (clr_q == IDX_W'(NUM_LINES - 1));
	assign st.cmd       = cmd_q;
	assign st.hit       = tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == tag);
	assign st.fill_done = (step_q == STEP_W'(LINE_BYTES));
	assign st.acc_done  = (step_q == cnt_ext);
	assign st.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			step_q      <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
		end else begin
			if (ctrl.tag_clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctrl.step_clr) begin
				step_q <= '0;
			end else if (ctrl.step_inc) begin
				step_q <= step_q + 1'b1;
			end
			rd_pend_q <= rd_issue;
			if (ctrl.accept) begin
				hit_q <= 1'b0;
			end else if (ctrl.eval) begin
				hit_q <= st.hit;
			end
			if (ctrl.count_hit) begin
				hits_q <= hits_q + 1'b1;
			end
			if (ctrl.count_miss) begin
				misses_q <= misses_q + 1'b1;
			end
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_q   <= in_command;
			addr_q  <= in_address;
			wdata_q <= in_store_data;
			cnt_q   <= cnt_sat;
		end
		rd_lane_q <= step_q[LANE_W-1:0];
		if (ctrl.accept) begin
			rdata_q <= '0;
		end else if (rd_pend_q) begin
			rdata_q[{rd_lane_q, 3'b000} +: 8] <= line_rdata;
		end
		if (ctrl.out_load) begin
			out_read_data    <= rdata_q;
			out_was_hit      <= hit_q;
			out_hits_total   <= hits_q;
			out_misses_total <= misses_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the direct-mapped write-through cache.
`timescale 1ns / 100ps

module testbench;
	import dmc_pkg::*;

	// Command code that the block must answer but otherwise ignore.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int OFF_W = $clog2(LINE_BYTES_DEF);
	localparam int LINE_ADDR_W = ADDR_W - OFF_W;
	localparam int HOT_LINES = 12;

	// Watchdog limit on the run length, with a wide margin over the slowest legal run.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 332;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              was_hit;
		logic [31:0]       hits_total;
		logic [31:0]       misses_total;
	} rsp_t;

	// Mirror of the cache and backing memory; predicts one response per
	// request transfer and checks response transfers against them in order.
	class cache_mirror;
		bit          line_ok   [NUM_LINES_DEF];
		bit [1:0]    line_tag  [NUM_LINES_DEF];
		bit [7:0]    line_data [NUM_LINES_DEF * LINE_BYTES_DEF];
		bit [7:0]    mem_data  [MEM_BYTES_DEF];
		bit          mem_seen  [MEM_BYTES_DEF];
		bit [31:0]   hit_tally;
		bit [31:0]   miss_tally;
		rsp_t        awaited[$];
		int          faults;

		// Offset of the first never-written byte a fill for addr would read,
		// or -1 when the access hits or its line is fully loaded.
		function int first_unloaded(logic [ADDR_W-1:0] addr);
			int idx;
			idx = addr[ADDR_W-3:OFF_W];
			if (line_ok[idx] && line_tag[idx] == addr[ADDR_W-1:ADDR_W-2])
				return -1;
			for (int i = 0; i < LINE_BYTES_DEF; i++)
				if (!mem_seen[{addr[ADDR_W-1:OFF_W], OFF_W'(i)}])
					return i;
			return -1;
		endfunction

		function void take_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
				logic [DATA_W-1:0] wdata, logic [CNT_W-1:0] cnt_in);
			int   n;
			int   off;
			int   idx;
			int   base;
			int   m;
			rsp_t want;
			n = (cnt_in > MAX_COUNT) ? MAX_COUNT : cnt_in;
			off = addr % LINE_BYTES_DEF;
			idx = (addr / LINE_BYTES_DEF) % NUM_LINES_DEF;
			base = addr - off;
			want = '0;
			if (cmd == CMD_READ || cmd == CMD_WRITE) begin
				want.was_hit = line_ok[idx] &&
					line_tag[idx] == addr / (NUM_LINES_DEF * LINE_BYTES_DEF);
				if (want.was_hit) begin
					hit_tally++;
				end else begin
					// allocate: whole line from memory
					for (int i = 0; i < LINE_BYTES_DEF; i++)
						line_data[idx * LINE_BYTES_DEF + i] = mem_data[(base + i) % MEM_BYTES_DEF];
					line_tag[idx] = 2'(addr / (NUM_LINES_DEF * LINE_BYTES_DEF));
					line_ok[idx] = 1'b1;
					miss_tally++;
				end
				for (int i = 0; i < n; i++) begin
					if (off + i < LINE_BYTES_DEF) begin
						if (cmd == CMD_READ) begin
							want.read_data[8*i +: 8] = line_data[idx * LINE_BYTES_DEF + off + i];
						end else begin
							m = (addr + i) % MEM_BYTES_DEF;
							line_data[idx * LINE_BYTES_DEF + off + i] = wdata[8*i +: 8];
							mem_data[m] = wdata[8*i +: 8];
							mem_seen[m] = 1'b1;
						end
					end
				end
			end else if (cmd == CMD_LOAD) begin
				for (int i = 0; i < n; i++) begin
					m = (addr + i) % MEM_BYTES_DEF;
					mem_data[m] = wdata[8*i +: 8];
					mem_seen[m] = 1'b1;
				end
			end
			want.hits_total = hit_tally;
			want.misses_total = miss_tally;
			awaited.push_back(want);
		endfunction

		function void match_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				$display("%0t: response with nothing outstanding: expected none, got %h",
					$time, got);
				faults++;
				return;
			end
			want = awaited.pop_front();
			if (got.read_data !== want.read_data) begin
				$display("%0t: read_data expected %h, got %h", $time, want.read_data,
					got.read_data);
				faults++;
			end
			if (got.was_hit !== want.was_hit) begin
				$display("%0t: was_hit expected %b, got %b", $time, want.was_hit, got.was_hit);
				faults++;
			end
			if (got.hits_total !== want.hits_total) begin
				$display("%0t: hits_total expected %0d, got %0d", $time, want.hits_total,
					got.hits_total);
				faults++;
			end
			if (got.misses_total !== want.misses_total) begin
				$display("%0t: misses_total expected %0d, got %0d", $time, want.misses_total,
					got.misses_total);
				faults++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dmc_req_if req_ch ();
	dmc_rsp_if rsp_ch ();

	direct_mapped_write_through_cache_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	cache_mirror mirror;

	// Idle/stall percentages for the current phase.
	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count = 0;

	// A few line addresses that share a handful of indexes, so random
	// traffic mixes hits with conflict misses instead of cold misses only.
	logic [LINE_ADDR_W-1:0] hot_lines [HOT_LINES];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Response side: check a transfer on the values seen before the edge,
	// then pick ready for the next cycle.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			mirror.match_response({rsp_ch.read_data, rsp_ch.was_hit, rsp_ch.hits_total,
				rsp_ch.misses_total});
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Drive one request until it transfers, note it, then maybe go idle.
	// Payload keeps toggling while valid is low.
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data, input logic [CNT_W-1:0] cnt);
		req_ch.valid      <= 1'b1;
		req_ch.command    <= cmd;
		req_ch.address    <= addr;
		req_ch.store_data <= data;
		req_ch.byte_count <= cnt;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		mirror.take_request(cmd, addr, data, cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid      <= 1'b0;
			req_ch.command    <= CMD_W'($urandom);
			req_ch.address    <= ADDR_W'($urandom);
			req_ch.store_data <= {$urandom, $urandom};
			req_ch.byte_count <= CNT_W'($urandom);
			@(posedge clk);
		end
	endtask

	// Hold valid low until every predicted response has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (mirror.awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic refresh_hot_lines();
		logic [LINE_ADDR_W-3:0] idx_pick [4];
		for (int k = 0; k < 4; k++)
			idx_pick[k] = (LINE_ADDR_W-2)'($urandom);
		for (int k = 0; k < HOT_LINES; k++)
			hot_lines[k] = {2'($urandom_range(3)), idx_pick[k % 4]};
	endtask

	// Random request, mostly reads and writes on the hot lines. An access
	// whose fill would touch never-written memory turns into a load of
	// the missing half line instead.
	task automatic pick_request(output logic [CMD_W-1:0] cmd, output logic [ADDR_W-1:0] addr,
			output logic [DATA_W-1:0] data, output logic [CNT_W-1:0] cnt);
		int r;
		int hole;
		r = $urandom_range(99);
		data = {$urandom, $urandom};
		if ($urandom_range(99) < 85)
			cnt = CNT_W'($urandom_range(1, MAX_COUNT));
		else
			cnt = CNT_W'($urandom_range(0, 15));
		addr = {hot_lines[$urandom_range(HOT_LINES - 1)], OFF_W'($urandom_range(15))};
		if (r < 45) begin
			cmd = CMD_READ;
		end else if (r < 78) begin
			cmd = CMD_WRITE;
		end else if (r < 90) begin
			cmd = CMD_LOAD;
			if ($urandom_range(1))
				addr = ADDR_W'($urandom);
		end else if (r < 96) begin
			cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
			addr = ADDR_W'($urandom);
		end else begin
			cmd = CMD_UNUSED;
			addr = ADDR_W'($urandom);
		end
		if (cmd == CMD_READ || cmd == CMD_WRITE) begin
			hole = mirror.first_unloaded(addr);
			if (hole >= 0) begin
				cmd = CMD_LOAD;
				addr = {addr[ADDR_W-1:OFF_W], OFF_W'(hole & MAX_COUNT)};
				cnt = CNT_W'(MAX_COUNT);
			end
		end
	endtask

	initial begin
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  cnt;
		int idle_tab  [4];
		int stall_tab [4];

		// phases: no idling, sender idle, receiver stalling, both
		idle_tab  = '{0, 65, 0, 21};
		stall_tab = '{0, 0, 65, 21};

		mirror = new;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.command    <= CMD_READ;
		req_ch.address    <= '0;
		req_ch.store_data <= '0;
		req_ch.byte_count <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The first request also waits out the tag clear.
		// Line 0: fill it, then hit, overrun the line end, zero and
		// oversized counts, write through on a hit.
		send_request(CMD_LOAD,  16'h0000, 64'h0123_4567_89AB_CDEF, 4'd8);
		send_request(CMD_LOAD,  16'h0008, '1, 4'd8);
		send_request(CMD_READ,  16'h0000, '0, 4'd8);
		send_request(CMD_READ,  16'h0008, '0, 4'd8);
		send_request(CMD_READ,  16'h000C, '0, 4'd8);
		send_request(CMD_READ,  16'h000F, '0, 4'd1);
		send_request(CMD_READ,  16'h0000, '0, 4'd0);
		send_request(CMD_READ,  16'h0003, '0, 4'hF);
		send_request(CMD_WRITE, 16'h0005, 64'hDEAD_BEEF_5A5A_A5A5, 4'd4);
		send_request(CMD_READ,  16'h0000, '0, 4'd8);
		// Loads at the top of memory, one wrapping round to address zero;
		// the cached copy of line 0 stays stale.
		send_request(CMD_LOAD,  16'hFFF8, {$urandom, $urandom}, 4'd8);
		send_request(CMD_LOAD,  16'hFFFC, {$urandom, $urandom}, 4'd8);
		send_request(CMD_LOAD,  16'hFFF0, {$urandom, $urandom}, 4'd8);
		send_request(CMD_READ,  16'hFFF0, '0, 4'd8);
		send_request(CMD_READ,  16'hFFFA, '0, 4'd8);
		// Same index, other tag: write allocate on a conflict miss.
		send_request(CMD_LOAD,  16'h3FF0, '0, 4'd8);
		send_request(CMD_LOAD,  16'h3FF8, {$urandom, $urandom}, 4'd8);
		send_request(CMD_WRITE, 16'h3FF8, '1, 4'd8);
		send_request(CMD_READ,  16'hFFF0, '0, 4'd8);
		send_request(CMD_WRITE, 16'h3FFE, {$urandom, $urandom}, 4'd8);
		send_request(CMD_WRITE, 16'h3FF0, '1, 4'd0);
		send_request(CMD_UNUSED, 16'h1234, '1, 4'd8);
		send_request(CMD_LOAD,  16'h4000, '1, 4'd0);
		send_request(CMD_LOAD,  16'h4000, {$urandom, $urandom}, 4'd12);
		send_request(CMD_READ,  16'hFFFF, '0, 4'd8);
		send_request(CMD_READ,  16'h0000, '0, 4'd8);

		for (int p = 0; p < 4; p++) begin
			// Full drain between phases: the sender waits on every response.
			wait_drained();
			send_idle_pct = idle_tab[p];
			recv_stall_pct = stall_tab[p];
			refresh_hot_lines();
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				pick_request(cmd, addr, data, cnt);
				send_request(cmd, addr, data, cnt);
			end
		end

		// Collect the rest, then let the receiver run free and watch for strays.
		wait_drained();
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.faults == 0 && mirror.awaited.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/dmc_pkg.sv
hdl/dmc_req_if.sv
hdl/dmc_rsp_if.sv
hdl/dmc_ram.sv
hdl/dmc_ctrl.sv
hdl/dmc_datapath.sv
hdl/direct_mapped_write_through_cache_top.sv
verif/testbench.sv
